FILE: src/slsc_pkg.sv
// Shared types and constants for the spotlight luminance scaler.
// Used by slsc_isqrt, spotlight_luminance_scaler_top and its testbench; depends on nothing.
`timescale 1ns / 1ps

package slsc_pkg;

    localparam int CENTER_BITS  = 14;
    localparam int DIFF_BITS    = 15;
    localparam int DIST_BITS    = 8;
    localparam int SQ_BITS      = 16;
    localparam int SUM_BITS     = 17;
    localparam int SQRT_LAT     = 4;
    localparam int CFG_IDX_BITS = 1;

    localparam int NEAR_LIMIT    = 160;
    localparam int NEAR_SQ_LIMIT = 25921;
    localparam int FULL_SPAN     = 200;
    localparam int FAR_FACTOR    = 40;
    localparam int SPAN_SHIFT    = 3;
    localparam int SPAN_ODD      = 25;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 1'b1;

    typedef logic [CENTER_BITS-1:0] t_center;
    typedef logic [SQ_BITS-1:0]     t_square;
    typedef logic [DIST_BITS-1:0]   t_dist;

endpackage

FILE: src/slsc_isqrt.sv
// Pipelined floor square root of a 16-bit value, two result bits per stage.
// Depends on slsc_pkg for widths and the stage count.
`timescale 1ns / 1ps

module slsc_isqrt (
    input  logic            i_clk,
    input  slsc_pkg::t_square i_n,
    output slsc_pkg::t_dist   o_root
);
    import slsc_pkg::*;

    localparam int REM_BITS = 10;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [DIST_BITS-1:0] root;
        logic [SQ_BITS-1:0]   n;
    } t_sqrt_st;

    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        logic [REM_BITS+1:0] rem_sh;
        logic [REM_BITS+1:0] trial;
        logic [REM_BITS+1:0] diff;
        t_sqrt_st            o;
        rem_sh = {s.rem, s.n[SQ_BITS-1 -: 2]};
        trial  = {{(REM_BITS-DIST_BITS){1'b0}}, s.root, 2'b01};
        diff   = rem_sh - trial;
        o.n    = s.n << 2;
        if (rem_sh >= trial) begin
            o.rem  = diff[REM_BITS-1:0];
            o.root = {s.root[DIST_BITS-2:0], 1'b1};
        end else begin
            o.rem  = rem_sh[REM_BITS-1:0];
            o.root = {s.root[DIST_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    t_sqrt_st r_st [0:SQRT_LAT-1];

    for (genvar g = 0; g < SQRT_LAT; g++) begin : g_stage
        t_sqrt_st w_in;
        if (g == 0) begin : g_first
            assign w_in = '{rem: '0, root: '0, n: i_n};
        end else begin : g_next
            assign w_in = r_st[g-1];
        end
        always_ff @(posedge i_clk) begin
            r_st[g] <= sqrt_step(sqrt_step(w_in));
        end
    end

    assign o_root = r_st[SQRT_LAT-1].root;

endmodule

FILE: src/spotlight_luminance_scaler_top.sv
// Radial spotlight vignette on a luminance stream: top level.
// Depends on slsc_pkg and slsc_isqrt.
`timescale 1ns / 1ps

// Usage:
// A request is presented on i_pixel_x, i_pixel_y and i_lum_in with start high.
// busy is always low, so a request is taken in every cycle that start is high.
// Each request yields one result on o_lum_out, marked by o_done for one cycle,
// in request order.
// Throughput is one pixel per clock; the twelve-stage pipeline, with the square
// root spread over four stages and the divide by 200 done as a shift and a
// reciprocal multiply, sets the latency.
// The spotlight center is written through i_cfg_we, i_cfg_idx and i_cfg_data:
// index 0 is the center column, index 1 the center row, both two's complement.
// Write them only while no request is in flight.
// Reset clears both center registers to zero and drops all pending results.
// The receiver cannot stall; results appear on fixed cycles.

module spotlight_luminance_scaler_top #(
    parameter int COORD_BITS = 12,
    parameter int LUM_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [COORD_BITS-1:0]        i_pixel_x,
    input  logic [COORD_BITS-1:0]        i_pixel_y,
    input  logic [LUM_BITS:0]            i_lum_in,
    output logic                         o_done,
    output logic [LUM_BITS:0]            o_lum_out,
    input  logic                         i_cfg_we,
    input  logic [slsc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  slsc_pkg::t_center            i_cfg_data
);
    import slsc_pkg::*;

    localparam int NSTAGE    = 12;
    localparam int LW        = LUM_BITS + 1;
    localparam int PROD_BITS = LW + DIST_BITS;
    localparam int YW        = PROD_BITS - SPAN_SHIFT;
    localparam int QW        = YW - 4;
    localparam longint RECIP_L = (longint'(1) << YW) / SPAN_ODD;
    localparam logic [QW-1:0] RECIP = QW'(RECIP_L);
    localparam int ABS_BITS  = DIFF_BITS - 1;

    t_center r_center_x, r_center_y;
    logic [NSTAGE-1:0] r_vld;

    logic [DIFF_BITS-1:0] r_s1_dx, r_s1_dy;
    logic [LW-1:0]        r_s1_lum;
    t_square              r_s2_sqx, r_s2_sqy;
    logic                 r_s2_box;
    logic [LW-1:0]        r_s2_lum;
    t_square              r_s3_n;
    logic                 r_s3_near;
    logic [LW-1:0]        r_s3_lum;
    logic                 r_near_dl [0:SQRT_LAT-1];
    logic [LW-1:0]        r_lum_dl  [0:SQRT_LAT-1];
    t_dist                r_s8_mult;
    logic [LW-1:0]        r_s8_lum;
    logic [PROD_BITS-1:0] r_s9_prod;
    logic [YW+QW-1:0]     r_s10_rp;
    logic [YW-1:0]        r_s10_y;
    logic [QW-1:0]        r_s11_q;
    logic [YW-1:0]        r_s11_y;
    logic [LW-1:0]        r_s12_lum;

    logic [DIFF_BITS-1:0] n_dx, n_dy;
    logic [ABS_BITS-1:0]  ax, ay;
    logic [SUM_BITS-1:0]  sq_sum;
    t_dist                root;
    logic [YW-1:0]        n_y;
    logic [YW-1:0]        q_times;
    logic [YW-1:0]        rem;
    logic [QW-1:0]        q_fix;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_vld      <= '0;
        end else begin
            r_vld <= {r_vld[NSTAGE-2:0], start & ~busy};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CENTER_X: r_center_x <= i_cfg_data;
                    REG_CENTER_Y: r_center_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign n_dx = {{(DIFF_BITS-COORD_BITS){1'b0}}, i_pixel_x}
                - {{(DIFF_BITS-CENTER_BITS){r_center_x[CENTER_BITS-1]}}, r_center_x};
    assign n_dy = {{(DIFF_BITS-COORD_BITS){1'b0}}, i_pixel_y}
                - {{(DIFF_BITS-CENTER_BITS){r_center_y[CENTER_BITS-1]}}, r_center_y};

    always_comb begin
        logic [DIFF_BITS-1:0] neg_x, neg_y;
        neg_x = -r_s1_dx;
        neg_y = -r_s1_dy;
        ax = r_s1_dx[DIFF_BITS-1] ? neg_x[ABS_BITS-1:0] : r_s1_dx[ABS_BITS-1:0];
        ay = r_s1_dy[DIFF_BITS-1] ? neg_y[ABS_BITS-1:0] : r_s1_dy[ABS_BITS-1:0];
    end

    assign sq_sum = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};

    always_ff @(posedge i_clk) begin
        r_s1_dx  <= n_dx;
        r_s1_dy  <= n_dy;
        r_s1_lum <= i_lum_in;

        r_s2_sqx <= ax[DIST_BITS-1:0] * ax[DIST_BITS-1:0];
        r_s2_sqy <= ay[DIST_BITS-1:0] * ay[DIST_BITS-1:0];
        r_s2_box <= (ax <= ABS_BITS'(NEAR_LIMIT)) && (ay <= ABS_BITS'(NEAR_LIMIT));
        r_s2_lum <= r_s1_lum;

        r_s3_n    <= sq_sum[SQ_BITS-1:0];
        r_s3_near <= r_s2_box && (sq_sum < SUM_BITS'(NEAR_SQ_LIMIT));
        r_s3_lum  <= r_s2_lum;
    end

    slsc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_n    (r_s3_n),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        r_near_dl[0] <= r_s3_near;
        r_lum_dl[0]  <= r_s3_lum;
        for (int k = 1; k < SQRT_LAT; k++) begin
            r_near_dl[k] <= r_near_dl[k-1];
            r_lum_dl[k]  <= r_lum_dl[k-1];
        end
    end

    assign n_y     = r_s9_prod[PROD_BITS-1:SPAN_SHIFT];
    assign q_times = YW'({r_s11_q, 4'b0000}) + YW'({r_s11_q, 3'b000}) + YW'(r_s11_q);
    assign rem     = r_s11_y - q_times;
    assign q_fix   = (rem >= YW'(SPAN_ODD)) ? r_s11_q + QW'(1) : r_s11_q;

    always_ff @(posedge i_clk) begin
        r_s8_mult <= r_near_dl[SQRT_LAT-1] ? DIST_BITS'(FULL_SPAN) - root
                                            : DIST_BITS'(FAR_FACTOR);
        r_s8_lum  <= r_lum_dl[SQRT_LAT-1];

        r_s9_prod <= PROD_BITS'(r_s8_lum) * PROD_BITS'(r_s8_mult);

        r_s10_rp  <= (YW+QW)'(n_y) * (YW+QW)'(RECIP);
        r_s10_y   <= n_y;

        r_s11_q   <= r_s10_rp[YW+QW-1:YW];
        r_s11_y   <= r_s10_y;

        r_s12_lum <= q_fix[LW-1:0];
    end

    assign o_done    = r_vld[NSTAGE-1];
    assign o_lum_out = r_s12_lum;

endmodule

FILE: dv/spotlight_luminance_scaler_top_tb.sv
// Self-checking testbench for spotlight_luminance_scaler_top: streams pixel requests in
// random bursts, moves the spotlight center between phases and checks every scaled luminance.
// Depends on slsc_pkg and the RTL of spotlight_luminance_scaler_top.
`timescale 1ns / 1ps

module spotlight_luminance_scaler_top_tb;

    import slsc_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int LUM_BITS      = 16;
    localparam int PIPE_LAT      = 12;
    localparam int FAR_DIVISOR   = 5;
    localparam int RANDOM_PIXELS = 750;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_CAP     = 40;

    typedef enum logic {REQ_PIXEL, REQ_CENTER} t_req_kind;

    typedef struct {
        t_req_kind                 kind;
        logic [COORD_BITS-1:0]     px;
        logic [COORD_BITS-1:0]     py;
        logic [LUM_BITS:0]         lum;
        logic [CFG_IDX_BITS-1:0]   idx;
        t_center                   val;
    } t_req;

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        start     = 1'b0;
    logic                        busy;
    logic [COORD_BITS-1:0]       i_pixel_x = '0;
    logic [COORD_BITS-1:0]       i_pixel_y = '0;
    logic [LUM_BITS:0]           i_lum_in  = '0;
    logic                        o_done;
    logic [LUM_BITS:0]           o_lum_out;
    logic                        i_cfg_we  = 1'b0;
    logic [CFG_IDX_BITS-1:0]     i_cfg_idx = '0;
    t_center                     i_cfg_data = '0;

    t_req                        pending_q[$];
    logic [LUM_BITS:0]           lum_expected_q[$];
    t_center                     center_x_copy = '0;
    t_center                     center_y_copy = '0;
    int                          burst_left    = 20;
    int                          gap_left      = 0;
    int                          mismatch_count = 0;
    int                          cycle_count   = 0;

    spotlight_luminance_scaler_top #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_lum_in   (i_lum_in),
        .o_done     (o_done),
        .o_lum_out  (o_lum_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [LUM_BITS:0] scaled_lum(logic [COORD_BITS-1:0] px,
                                                     logic [COORD_BITS-1:0] py,
                                                     logic [LUM_BITS:0] lum,
                                                     t_center cx, t_center cy);
        longint dx, dy, dist_sq, root, trial, prod;
        dx = longint'(px) - longint'($signed(cx));
        dy = longint'(py) - longint'($signed(cy));
        dist_sq = dx * dx + dy * dy;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= dist_sq) begin
                root = trial;
            end
        end
        if (root <= NEAR_LIMIT) begin
            prod = longint'(lum) * (FULL_SPAN - root) / FULL_SPAN;
        end else begin
            prod = longint'(lum) / FAR_DIVISOR;
        end
        return prod[LUM_BITS:0];
    endfunction

    task automatic add_pixel(int x, int y, int lum);
        t_req r;
        r.kind = REQ_PIXEL;
        r.px   = x[COORD_BITS-1:0];
        r.py   = y[COORD_BITS-1:0];
        r.lum  = lum[LUM_BITS:0];
        r.idx  = '0;
        r.val  = '0;
        pending_q.push_back(r);
    endtask

    task automatic add_center(logic [CFG_IDX_BITS-1:0] idx, int val);
        t_req r;
        r.kind = REQ_CENTER;
        r.px   = '0;
        r.py   = '0;
        r.lum  = '0;
        r.idx  = idx;
        r.val  = t_center'(val);
        pending_q.push_back(r);
    endtask

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic int near_coord(int c);
        int v;
        v = c + int'($urandom_range(0, 440)) - 220;
        if (v < 0 || v > 4095) begin
            v = $urandom_range(0, 4095);
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : drive
        logic nxt_start;
        logic nxt_we;
        t_req head;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                lum_expected_q.push_back(scaled_lum(i_pixel_x, i_pixel_y, i_lum_in,
                                                    center_x_copy, center_y_copy));
                nxt_start = 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CENTER_X) begin
                    center_x_copy = i_cfg_data;
                end else if (i_cfg_idx == REG_CENTER_Y) begin
                    center_y_copy = i_cfg_data;
                end
            end
            if (!nxt_start && !i_cfg_we) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    head = pending_q[0];
                    if (head.kind == REQ_PIXEL) begin
                        void'(pending_q.pop_front());
                        i_pixel_x <= head.px;
                        i_pixel_y <= head.py;
                        i_lum_in  <= head.lum;
                        nxt_start = 1'b1;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end else if (lum_expected_q.size() == 0) begin
                        // The center only moves once every request in flight has come out.
                        void'(pending_q.pop_front());
                        i_cfg_idx  <= head.idx;
                        i_cfg_data <= head.val;
                        nxt_we = 1'b1;
                    end
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    always @(posedge i_clk) begin : check
        logic [LUM_BITS:0] want;
        if (i_rst_n && o_done) begin
            if (lum_expected_q.size() == 0) begin
                report_mismatch($sformatf("result with no request pending, lum_out=%0d",
                                          o_lum_out));
            end else begin
                want = lum_expected_q.pop_front();
                if (o_lum_out !== want) begin
                    report_mismatch($sformatf("lum_out=%0d, expected %0d", o_lum_out, want));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int cx;
        int cy;
        int x;
        int y;
        int lum;
        int drain;

        // Center at its reset value of zero: extremes, exact distance 160, and just past it.
        add_pixel(0, 0, 65536);
        add_pixel(0, 0, 131071);
        add_pixel(0, 0, 0);
        add_pixel(160, 0, 65536);
        add_pixel(96, 128, 100000);
        add_pixel(161, 0, 65536);
        add_pixel(0, 161, 131071);
        add_pixel(113, 113, 65536);
        add_pixel(1, 1, 99999);
        add_pixel(4095, 4095, 131071);
        add_center(REG_CENTER_X, -8192);
        add_center(REG_CENTER_Y, 8191);
        add_pixel(0, 0, 131071);
        add_pixel(4095, 4095, 65536);
        add_center(REG_CENTER_X, 8191);
        add_center(REG_CENTER_Y, -8192);
        add_pixel(0, 4095, 131071);
        add_pixel(4095, 0, 65536);
        add_center(REG_CENTER_X, 2000);
        add_center(REG_CENTER_Y, 3000);
        add_pixel(2000, 3000, 65536);
        add_pixel(2160, 3000, 65536);
        add_pixel(1840, 3000, 99999);
        add_pixel(2000, 3161, 65536);
        add_pixel(2096, 3128, 131071);

        n = 0;
        while (n < RANDOM_PIXELS) begin
            if ($urandom_range(0, 4) == 0) begin
                cx = int'($urandom_range(0, 16383)) - 8192;
                cy = int'($urandom_range(0, 16383)) - 8192;
            end else begin
                cx = int'($urandom_range(0, 4495)) - 200;
                cy = int'($urandom_range(0, 4495)) - 200;
            end
            add_center(REG_CENTER_X, cx);
            add_center(REG_CENTER_Y, cy);
            repeat ($urandom_range(30, 120)) begin
                if ($urandom_range(0, 9) < 7) begin
                    x = near_coord(cx);
                    y = near_coord(cy);
                end else begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                case ($urandom_range(0, 7))
                    0: lum = 0;
                    1: lum = 65536;
                    2: lum = $urandom_range(0, 131071);
                    default: lum = $urandom_range(0, 65536);
                endcase
                add_pixel(x, y, lum);
                n++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || i_cfg_we) begin
            @(posedge i_clk);
        end
        drain = 0;
        while (lum_expected_q.size() != 0 && drain < 8 * PIPE_LAT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (lum_expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      lum_expected_q.size()));
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/slsc_pkg.sv
src/slsc_isqrt.sv
src/spotlight_luminance_scaler_top.sv
dv/spotlight_luminance_scaler_top_tb.sv
